// ===== design/assert_macros.svh =====
// Assertion macros used by the dispatcher design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge while reset is released.
`define PSD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Checks that a condition implies another condition in the following cycle.
`define PSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/psd_pkg.sv =====
package psd_pkg;

  localparam int unsigned MAX_PROCS   = 64;
  localparam int unsigned PID_W       = 6;
  localparam int unsigned DEV_W       = 2;
  localparam int unsigned NUM_QUEUES  = 8;
  localparam int unsigned LEN_W       = 7;
  localparam int unsigned INFO_W      = 5;

  localparam logic [2:0] Q_NEW   = 3'd0;
  localparam logic [2:0] Q_READY = 3'd1;
  localparam logic [2:0] Q_RUN   = 3'd2;
  localparam logic [2:0] Q_BLK0  = 3'd3;
  localparam logic [2:0] Q_EXIT  = 3'd7;

  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_STEP    = 3'd1;
  localparam logic [2:0] OP_WAIT    = 3'd2;
  localparam logic [2:0] OP_IO      = 3'd3;
  localparam logic [2:0] OP_QUERY   = 3'd4;
  localparam logic [2:0] OP_RELEASE = 3'd5;

  localparam logic [2:0] STS_OK          = 3'd0;
  localparam logic [2:0] STS_HOSTED      = 3'd1;
  localparam logic [2:0] STS_NOTHING_RUN = 3'd3;
  localparam logic [2:0] STS_NO_WAITERS  = 3'd4;
  localparam logic [2:0] STS_NOT_HOSTED  = 3'd5;

  localparam logic [2:0] ST_NEW     = 3'd0;
  localparam logic [2:0] ST_READY   = 3'd1;
  localparam logic [2:0] ST_RUN     = 3'd2;
  localparam logic [2:0] ST_BLOCKED = 3'd3;
  localparam logic [2:0] ST_EXIT    = 3'd4;
  localparam logic [2:0] ST_ABSENT  = 3'd5;

  localparam logic [2:0] PH_NEW  = 3'd0;
  localparam logic [2:0] PH_BLK0 = 3'd1;
  localparam logic [2:0] PH_BLK3 = 3'd4;
  localparam logic [2:0] PH_RUN  = 3'd5;
  localparam logic [2:0] PH_DISP = 3'd6;

  localparam logic [1:0] CFG_TIMEOUT  = 2'd0;
  localparam logic [1:0] CFG_ADD      = 2'd1;
  localparam logic [1:0] CFG_DISPATCH = 2'd2;
  localparam logic [1:0] CFG_RELEASE  = 2'd3;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_ADD     = 11'b000_0000_0010,
    S_EXIT_RD = 11'b000_0000_0100,
    S_EXIT_WR = 11'b000_0000_1000,
    S_PICK    = 11'b000_0001_0000,
    S_TCMP    = 11'b000_0010_0000,
    S_MV_RD   = 11'b000_0100_0000,
    S_MV_WR   = 11'b000_1000_0000,
    S_CMD     = 11'b001_0000_0000,
    S_QRY     = 11'b010_0000_0000,
    S_DONE    = 11'b100_0000_0000
  } psd_state_e;

endpackage

// ===== design/psd_ram.sv =====
module psd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/process_state_dispatcher.sv =====
// Channel   Direction  tdata fields (lowest bit first)
// s_axis    in         operation[2:0] pid[8:3] device[10:9] now[42:11], zero pad
// m_axis    out        cost status running_valid running_pid query_state
//                      query_device query_since, zero pad
// cfg       in         write enable, register index, 32-bit data
// Add, query and commands that fail finish without moving a process.
// Wait and release move the running process; an I/O completion moves each waiter in turn.
// Step frees the exiting processes, checks each occupied blocked queue and then moves processes.
// Each move waits on the registered reads of the linked-list memories.
// No clearing pass is needed after reset; slot valid bits clear at once.
// A result waits in the output until m_axis_tready; no transaction is accepted meanwhile.
`include "assert_macros.svh"

module process_state_dispatcher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // operation, pid, device, now
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // cost, status, running_valid, running_pid,
                                      // query_state, query_device, query_since
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  psd_pkg::psd_state_e state_q, state_d;

  logic [2:0]  op_q, op_d;
  logic [5:0]  pid_q, pid_d;
  logic [1:0]  dev_q, dev_d;
  logic [31:0] now_q, now_d;
  logic [2:0]  ph_q, ph_d;
  logic [2:0]  src_q, src_d, dst_q, dst_d, mst_q, mst_d;
  logic        mtm_q, mtm_d;
  logic [5:0]  p_q, p_d;

  logic [31:0] tmo_q;
  logic [15:0] add_cost_q, disp_cost_q, rel_cost_q;

  logic [15:0] cost_q, cost_d;
  logic [2:0]  status_q, status_d, qst_q, qst_d;
  logic [1:0]  qdev_q, qdev_d;
  logic [31:0] qsince_q, qsince_d;

  logic [63:0] valid_q, valid_d;
  logic [5:0]  first_q [8];
  logic [5:0]  first_d [8];
  logic [5:0]  last_q [8];
  logic [5:0]  last_d [8];
  logic [6:0]  len_q [8];
  logic [6:0]  len_d [8];

  logic        n_we, i_we, t_we;
  logic [5:0]  n_waddr, n_wdata, n_raddr, n_rdata;
  logic [5:0]  i_waddr, i_raddr, t_waddr, t_raddr;
  logic [4:0]  i_wdata, i_rdata;
  logic [31:0] t_rdata;
  logic [2:0]  blk_q_idx;
  logic [5:0]  mv_p;
  logic        run_valid;
  logic [9:0]  occupancy;

  psd_ram #(.WIDTH(6), .DEPTH(64)) u_next_ram (
    .clk_i(clk_i), .we_i(n_we), .waddr_i(n_waddr), .wdata_i(n_wdata),
    .raddr_i(n_raddr), .rdata_o(n_rdata)
  );

  psd_ram #(.WIDTH(5), .DEPTH(64)) u_info_ram (
    .clk_i(clk_i), .we_i(i_we), .waddr_i(i_waddr), .wdata_i(i_wdata),
    .raddr_i(i_raddr), .rdata_o(i_rdata)
  );

  psd_ram #(.WIDTH(32), .DEPTH(64)) u_time_ram (
    .clk_i(clk_i), .we_i(t_we), .waddr_i(t_waddr), .wdata_i(now_q),
    .raddr_i(t_raddr), .rdata_o(t_rdata)
  );

  assign s_axis_tready = (state_q == psd_pkg::S_IDLE);
  assign m_axis_tvalid = (state_q == psd_pkg::S_DONE);
  assign run_valid     = (len_q[psd_pkg::Q_RUN] != 7'd0);
  assign m_axis_tdata  = {1'b0, qsince_q, qdev_q, qst_q,
                          (run_valid ? first_q[psd_pkg::Q_RUN] : 6'd0),
                          run_valid, status_q, cost_q};
  assign blk_q_idx     = 3'(psd_pkg::Q_BLK0 + ph_q - psd_pkg::PH_BLK0);
  assign mv_p          = first_q[src_q];

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    pid_d    = pid_q;
    dev_d    = dev_q;
    now_d    = now_q;
    ph_d     = ph_q;
    src_d    = src_q;
    dst_d    = dst_q;
    mst_d    = mst_q;
    mtm_d    = mtm_q;
    p_d      = p_q;
    cost_d   = cost_q;
    status_d = status_q;
    qst_d    = qst_q;
    qdev_d   = qdev_q;
    qsince_d = qsince_q;
    valid_d  = valid_q;
    first_d  = first_q;
    last_d   = last_q;
    len_d    = len_q;
    n_we     = 1'b0;
    n_waddr  = last_q[dst_q];
    n_wdata  = p_q;
    n_raddr  = mv_p;
    i_we     = 1'b0;
    i_waddr  = mv_p;
    i_wdata  = {mst_q, (mst_q == psd_pkg::ST_BLOCKED) ? dev_q : 2'd0};
    i_raddr  = pid_q;
    t_we     = 1'b0;
    t_waddr  = mv_p;
    t_raddr  = pid_q;

    case (state_q)
      psd_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d     = s_axis_tdata[2:0];
          pid_d    = s_axis_tdata[8:3];
          dev_d    = s_axis_tdata[10:9];
          now_d    = s_axis_tdata[42:11];
          ph_d     = psd_pkg::PH_NEW;
          cost_d   = 16'd0;
          status_d = psd_pkg::STS_OK;
          qst_d    = 3'd0;
          qdev_d   = 2'd0;
          qsince_d = 32'd0;
          if (s_axis_tdata[2:0] == psd_pkg::OP_ADD) begin
            state_d = psd_pkg::S_ADD;
          end else if (s_axis_tdata[2:0] == psd_pkg::OP_STEP) begin
            cost_d  = 16'd1;
            state_d = psd_pkg::S_EXIT_RD;
          end else begin
            state_d = psd_pkg::S_CMD;
          end
        end
      end
      psd_pkg::S_ADD: begin
        state_d = psd_pkg::S_DONE;
        if (valid_q[pid_q]) begin
          status_d = psd_pkg::STS_HOSTED;
        end else begin
          valid_d[pid_q] = 1'b1;
          i_we    = 1'b1;
          i_waddr = pid_q;
          i_wdata = {psd_pkg::ST_NEW, 2'd0};
          t_we    = 1'b1;
          t_waddr = pid_q;
          if (len_q[psd_pkg::Q_NEW] == 7'd0) begin
            first_d[psd_pkg::Q_NEW] = pid_q;
          end else begin
            n_we    = 1'b1;
            n_waddr = last_q[psd_pkg::Q_NEW];
            n_wdata = pid_q;
          end
          last_d[psd_pkg::Q_NEW] = pid_q;
          len_d[psd_pkg::Q_NEW]  = len_q[psd_pkg::Q_NEW] + 7'd1;
          cost_d = add_cost_q;
        end
      end
      psd_pkg::S_EXIT_RD: begin
        if (len_q[psd_pkg::Q_EXIT] == 7'd0) begin
          state_d = psd_pkg::S_PICK;
        end else begin
          n_raddr = first_q[psd_pkg::Q_EXIT];
          valid_d[first_q[psd_pkg::Q_EXIT]] = 1'b0;
          state_d = psd_pkg::S_EXIT_WR;
        end
      end
      psd_pkg::S_EXIT_WR: begin
        first_d[psd_pkg::Q_EXIT] = n_rdata;
        len_d[psd_pkg::Q_EXIT]   = len_q[psd_pkg::Q_EXIT] - 7'd1;
        state_d = psd_pkg::S_EXIT_RD;
      end
      psd_pkg::S_PICK: begin
        if (ph_q == psd_pkg::PH_NEW) begin
          if (len_q[psd_pkg::Q_NEW] != 7'd0) begin
            src_d = psd_pkg::Q_NEW;
            dst_d = psd_pkg::Q_READY;
            mst_d = psd_pkg::ST_READY;
            mtm_d = 1'b0;
            state_d = psd_pkg::S_MV_RD;
          end else begin
            ph_d = ph_q + 3'd1;
          end
        end else if (ph_q inside {[psd_pkg::PH_BLK0:psd_pkg::PH_BLK3]}) begin
          if (len_q[blk_q_idx] != 7'd0) begin
            t_raddr = first_q[blk_q_idx];
            state_d = psd_pkg::S_TCMP;
          end else begin
            ph_d = ph_q + 3'd1;
          end
        end else if (ph_q == psd_pkg::PH_RUN) begin
          if (run_valid) begin
            src_d = psd_pkg::Q_RUN;
            dst_d = psd_pkg::Q_READY;
            mst_d = psd_pkg::ST_READY;
            mtm_d = 1'b1;
            state_d = psd_pkg::S_MV_RD;
          end else begin
            ph_d = ph_q + 3'd1;
          end
        end else begin
          if (len_q[psd_pkg::Q_READY] != 7'd0) begin
            src_d  = psd_pkg::Q_READY;
            dst_d  = psd_pkg::Q_RUN;
            mst_d  = psd_pkg::ST_RUN;
            mtm_d  = 1'b0;
            cost_d = disp_cost_q;
            state_d = psd_pkg::S_MV_RD;
          end else begin
            state_d = psd_pkg::S_DONE;
          end
        end
      end
      psd_pkg::S_TCMP: begin
        if ((now_q - t_rdata) >= tmo_q) begin
          src_d = blk_q_idx;
          dst_d = psd_pkg::Q_READY;
          mst_d = psd_pkg::ST_READY;
          mtm_d = 1'b0;
          state_d = psd_pkg::S_MV_RD;
        end else begin
          ph_d    = ph_q + 3'd1;
          state_d = psd_pkg::S_PICK;
        end
      end
      psd_pkg::S_MV_RD: begin
        p_d     = mv_p;
        i_we    = 1'b1;
        t_we    = mtm_q;
        state_d = psd_pkg::S_MV_WR;
      end
      psd_pkg::S_MV_WR: begin
        first_d[src_q] = n_rdata;
        len_d[src_q]   = len_q[src_q] - 7'd1;
        if (len_q[dst_q] == 7'd0) begin
          first_d[dst_q] = p_q;
        end else begin
          n_we = 1'b1;
        end
        last_d[dst_q] = p_q;
        len_d[dst_q]  = len_q[dst_q] + 7'd1;
        if (op_q == psd_pkg::OP_STEP) begin
          if (ph_q == psd_pkg::PH_DISP) begin
            state_d = psd_pkg::S_DONE;
          end else begin
            ph_d    = ph_q + 3'd1;
            state_d = psd_pkg::S_PICK;
          end
        end else if (op_q == psd_pkg::OP_IO && len_q[src_q] > 7'd1) begin
          state_d = psd_pkg::S_MV_RD;
        end else begin
          state_d = psd_pkg::S_DONE;
        end
      end
      psd_pkg::S_CMD: begin
        state_d = psd_pkg::S_DONE;
        case (op_q)
          psd_pkg::OP_WAIT: begin
            if (!run_valid) begin
              status_d = psd_pkg::STS_NOTHING_RUN;
            end else begin
              src_d  = psd_pkg::Q_RUN;
              dst_d  = 3'(psd_pkg::Q_BLK0 + {1'b0, dev_q});
              mst_d  = psd_pkg::ST_BLOCKED;
              mtm_d  = 1'b1;
              cost_d = 16'd1;
              state_d = psd_pkg::S_MV_RD;
            end
          end
          psd_pkg::OP_IO: begin
            cost_d = 16'd1;
            if (len_q[3'(psd_pkg::Q_BLK0 + {1'b0, dev_q})] == 7'd0) begin
              status_d = psd_pkg::STS_NO_WAITERS;
            end else begin
              src_d = 3'(psd_pkg::Q_BLK0 + {1'b0, dev_q});
              dst_d = psd_pkg::Q_READY;
              mst_d = psd_pkg::ST_READY;
              mtm_d = 1'b0;
              state_d = psd_pkg::S_MV_RD;
            end
          end
          psd_pkg::OP_QUERY: begin
            state_d = psd_pkg::S_QRY;
          end
          psd_pkg::OP_RELEASE: begin
            if (!run_valid) begin
              status_d = psd_pkg::STS_NOTHING_RUN;
            end else begin
              src_d  = psd_pkg::Q_RUN;
              dst_d  = psd_pkg::Q_EXIT;
              mst_d  = psd_pkg::ST_EXIT;
              mtm_d  = 1'b1;
              cost_d = rel_cost_q;
              state_d = psd_pkg::S_MV_RD;
            end
          end
          default: begin
            state_d = psd_pkg::S_DONE;
          end
        endcase
      end
      psd_pkg::S_QRY: begin
        state_d = psd_pkg::S_DONE;
        if (!valid_q[pid_q]) begin
          status_d = psd_pkg::STS_NOT_HOSTED;
          qst_d    = psd_pkg::ST_ABSENT;
        end else begin
          qst_d    = i_rdata[4:2];
          qdev_d   = (i_rdata[4:2] == psd_pkg::ST_BLOCKED) ? i_rdata[1:0] : 2'd0;
          qsince_d = t_rdata;
        end
      end
      psd_pkg::S_DONE: begin
        if (m_axis_tready) begin
          state_d = psd_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = psd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psd_pkg::S_IDLE;
      valid_q     <= '0;
      len_q       <= '{default: '0};
      tmo_q       <= 32'd1024;
      add_cost_q  <= 16'd32;
      disp_cost_q <= 16'd256;
      rel_cost_q  <= 16'd32;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      len_q   <= len_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          psd_pkg::CFG_TIMEOUT:  tmo_q       <= cfg_data_i;
          psd_pkg::CFG_ADD:      add_cost_q  <= cfg_data_i[15:0];
          psd_pkg::CFG_DISPATCH: disp_cost_q <= cfg_data_i[15:0];
          psd_pkg::CFG_RELEASE:  rel_cost_q  <= cfg_data_i[15:0];
          default: begin
            tmo_q <= tmo_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    pid_q    <= pid_d;
    dev_q    <= dev_d;
    now_q    <= now_d;
    ph_q     <= ph_d;
    src_q    <= src_d;
    dst_q    <= dst_d;
    mst_q    <= mst_d;
    mtm_q    <= mtm_d;
    p_q      <= p_d;
    cost_q   <= cost_d;
    status_q <= status_d;
    qst_q    <= qst_d;
    qdev_q   <= qdev_d;
    qsince_q <= qsince_d;
    first_q  <= first_d;
    last_q   <= last_d;
  end

  always_comb begin
    occupancy = '0;
    for (int i = 0; i < 8; i++) begin
      occupancy = occupancy + 10'(len_q[i]);
    end
  end

  `PSD_ASSERT(a_one_running, clk_i, rst_ni, len_q[psd_pkg::Q_RUN] <= 7'd1)
  `PSD_ASSERT(a_occupancy, clk_i, rst_ni, occupancy <= 10'(psd_pkg::MAX_PROCS))
  `PSD_ASSERT_NEXT(a_step_starts_exit, clk_i, rst_ni,
                   s_axis_tvalid && s_axis_tready && s_axis_tdata[2:0] == psd_pkg::OP_STEP,
                   state_q == psd_pkg::S_EXIT_RD)

endmodule
